/* src/pprp_pkg.sv */
// ----------------------------------------------------------------------------
// pprp_pkg
// Shared types and constants for the ping-pong receive read planner.
// ----------------------------------------------------------------------------
`default_nettype none

package pprp_pkg;

  localparam int RX_BUF_BYTES = 'h4000;
  localparam int HALF_SIZE    = RX_BUF_BYTES / 4;
  localparam int CYCLE_SIZE   = RX_BUF_BYTES / 2;

  localparam int PTR_W  = 14;
  localparam int LEN_W  = 13;
  localparam int OFF_W  = 13;
  localparam int MRL_W  = 14;
  localparam int MODE_W = 2;
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;

  localparam logic [MRL_W-1:0] MAX_READ_LEN_RESET = MRL_W'(4096);

  localparam logic REG_MAX_READ_LEN = 1'b0;

  typedef enum logic [MODE_W-1:0] {
    MODE_IDLE     = 2'd0,
    MODE_LISTEN   = 2'd1,
    MODE_OVERFLOW = 2'd2
  } mode_t;

endpackage

`default_nettype wire

/* src/pingpong_rx_read_planner.sv */
// ----------------------------------------------------------------------------
// pingpong_rx_read_planner
// Plans reads from a double-buffered receive memory, one register snapshot
// per beat, and the register refill or overflow recovery that follows.
// ----------------------------------------------------------------------------
// Each input beat is a snapshot of the receiver's registers; each produces
// exactly one result beat. The block accepts one beat per clock cycle while
// the output is not stalled. A result is presented on the output once the
// beat has moved from the input register into the result register, and is
// held there until taken at a clock edge with out_stall low. The sustained
// rate of one beat per cycle is set by the read offset register, which is
// read and rewritten whenever a beat moves into the result register.
// The maximum read length register sits at byte address 0 of the APB port.
`default_nettype none

module pingpong_rx_read_planner
  import pprp_pkg::*;
(
  input  wire                    clk,
  input  wire                    rst_n,

  input  wire                    in_valid,
  output logic                   in_stall,
  input  wire  [PTR_W-1:0]       in_rx_ptr,
  input  wire  [LEN_W-1:0]       in_rx_len,
  input  wire  [PTR_W-1:0]       in_rx_ptr_alt,
  input  wire  [LEN_W-1:0]       in_rx_len_alt,
  input  wire  [MODE_W-1:0]      in_rx_mode,

  output logic                   out_valid,
  input  wire                    out_stall,
  output logic [OFF_W-1:0]       out_prime_addr,
  output logic [LEN_W-1:0]       out_prime_len,
  output logic [OFF_W-1:0]       out_flip_addr,
  output logic [LEN_W-1:0]       out_flip_len,
  output logic                   out_update_all,
  output logic                   out_update_alt,
  output logic                   out_progress_ok,
  output logic [PTR_W-1:0]       out_new_ptr,
  output logic [LEN_W-1:0]       out_new_len,
  output logic [PTR_W-1:0]       out_new_ptr_alt,
  output logic [LEN_W-1:0]       out_new_len_alt,
  output logic [MODE_W-1:0]      out_new_mode,

  input  wire                    psel,
  input  wire                    penable,
  input  wire                    pwrite,
  input  wire  [ADDR_W-1:0]      paddr,
  input  wire  [DATA_W-1:0]      pwdata,
  output logic [DATA_W-1:0]      prdata,
  output logic                   pready
);

  localparam logic [OFF_W-1:0] HALF_OFF   = OFF_W'(HALF_SIZE);
  localparam logic [PTR_W-1:0] HALF_PTR   = PTR_W'(HALF_SIZE);
  localparam logic [LEN_W-1:0] HALF_LEN   = LEN_W'(HALF_SIZE);
  localparam logic [PTR_W:0]   END_HALF   = (PTR_W+1)'(HALF_SIZE);
  localparam logic [PTR_W:0]   END_CYCLE  = (PTR_W+1)'(CYCLE_SIZE);

  logic [MRL_W-1:0]  max_read_len_r;
  logic [OFF_W-1:0]  read_offset_r;
  logic [OFF_W-1:0]  read_offset_nxt;

  logic              s0_valid_r;
  logic [PTR_W-1:0]  s0_ptr_r;
  logic [LEN_W-1:0]  s0_len_r;
  logic [PTR_W-1:0]  s0_ptr_alt_r;
  logic [LEN_W-1:0]  s0_len_alt_r;
  logic [MODE_W-1:0] s0_mode_r;

  logic              out_valid_r;
  logic [OFF_W-1:0]  prime_addr_r, prime_addr_nxt;
  logic [LEN_W-1:0]  prime_len_r, prime_len_nxt;
  logic [OFF_W-1:0]  flip_addr_r, flip_addr_nxt;
  logic [LEN_W-1:0]  flip_len_r, flip_len_nxt;
  logic              update_all_r, update_all_nxt;
  logic              update_alt_r, update_alt_nxt;
  logic              progress_ok_r, progress_ok_nxt;
  logic [PTR_W-1:0]  new_ptr_r, new_ptr_nxt;
  logic [LEN_W-1:0]  new_len_r, new_len_nxt;
  logic [PTR_W-1:0]  new_ptr_alt_r, new_ptr_alt_nxt;
  logic [LEN_W-1:0]  new_len_alt_r, new_len_alt_nxt;
  logic [MODE_W-1:0] new_mode_r, new_mode_nxt;

  logic advance;
  logic in_accept;
  logic cfg_write;

  assign advance   = s0_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = s0_valid_r && !advance;
  assign in_accept = in_valid && !in_stall;
  assign cfg_write = psel && penable && pwrite && pready;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_MAX_READ_LEN) ? DATA_W'(max_read_len_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_read_len_r <= MAX_READ_LEN_RESET;
    end else if (cfg_write && paddr[2] == REG_MAX_READ_LEN) begin
      max_read_len_r <= pwdata[MRL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
    end else if (in_accept) begin
      s0_valid_r <= 1'b1;
    end else if (advance) begin
      s0_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s0_ptr_r     <= in_rx_ptr;
      s0_len_r     <= in_rx_len;
      s0_ptr_alt_r <= in_rx_ptr_alt;
      s0_len_alt_r <= in_rx_len_alt;
      s0_mode_r    <= in_rx_mode;
    end
  end

  logic              cur_half;
  logic [OFF_W-1:0]  hoff;
  logic [OFF_W-1:0]  room;
  logic [OFF_W-1:0]  other_base;
  logic              alt_unset;
  logic [PTR_W-1:0]  rl_raw;
  logic [PTR_W-1:0]  rf_raw;
  logic [LEN_W-1:0]  rl_sat;
  logic [LEN_W-1:0]  rf_sat;
  logic [MRL_W-1:0]  rem;
  logic [LEN_W-1:0]  rl_fin;
  logic [LEN_W-1:0]  rf_fin;
  logic [OFF_W:0]    off_sum;
  logic [OFF_W-1:0]  off_adv;
  logic [PTR_W:0]    end_prime;
  logic              end_is_half;
  logic              end_is_cycle;
  logic              unread_alt;
  logic [PTR_W-1:0]  new_base;

  always_comb begin
    cur_half   = read_offset_r[OFF_W-1];
    hoff       = {1'b0, read_offset_r[OFF_W-2:0]};
    room       = HALF_OFF - hoff;
    other_base = cur_half ? '0 : HALF_OFF;
    alt_unset  = (s0_ptr_alt_r == '0) && (s0_len_alt_r == '0);

    if (alt_unset) begin
      rl_raw = {1'b0, room};
      rf_raw = (s0_ptr_r > {1'b0, other_base}) ? s0_ptr_r - {1'b0, other_base} : '0;
    end else begin
      rl_raw = (s0_ptr_r > {1'b0, read_offset_r}) ? s0_ptr_r - {1'b0, read_offset_r} : '0;
      rf_raw = '0;
    end

    rl_sat = (rl_raw > {1'b0, room}) ? room : rl_raw[LEN_W-1:0];
    rf_sat = (rf_raw > HALF_PTR) ? HALF_LEN : rf_raw[LEN_W-1:0];

    rem = '0;
    if ({1'b0, rl_sat} > max_read_len_r) begin
      rl_fin = max_read_len_r[LEN_W-1:0];
      rf_fin = '0;
    end else begin
      rem    = max_read_len_r - {1'b0, rl_sat};
      rl_fin = rl_sat;
      rf_fin = ({1'b0, rf_sat} > rem) ? rem[LEN_W-1:0] : rf_sat;
    end

    off_sum = {1'b0, read_offset_r} + {1'b0, rl_fin} + {1'b0, rf_fin};
    off_adv = off_sum[OFF_W-1:0];

    end_prime    = {1'b0, s0_ptr_r} + {2'b00, s0_len_r};
    end_is_half  = (end_prime == END_HALF);
    end_is_cycle = (end_prime == END_CYCLE);
    unread_alt   = off_adv[OFF_W-1] ? end_is_half : end_is_cycle;
    new_base     = end_is_cycle ? '0 : HALF_PTR;
  end

  always_comb begin
    prime_addr_nxt  = read_offset_r;
    prime_len_nxt   = rl_fin;
    flip_addr_nxt   = other_base;
    flip_len_nxt    = rf_fin;
    update_all_nxt  = 1'b0;
    update_alt_nxt  = 1'b0;
    progress_ok_nxt = 1'b1;
    new_ptr_nxt     = s0_ptr_r;
    new_len_nxt     = s0_len_r;
    new_ptr_alt_nxt = s0_ptr_alt_r;
    new_len_alt_nxt = s0_len_alt_r;
    new_mode_nxt    = s0_mode_r;
    read_offset_nxt = off_adv;

    case (mode_t'(s0_mode_r))
      MODE_IDLE: begin
        prime_addr_nxt  = '0;
        prime_len_nxt   = '0;
        flip_addr_nxt   = '0;
        flip_len_nxt    = '0;
        update_all_nxt  = 1'b1;
        progress_ok_nxt = 1'b0;
        new_ptr_nxt     = '0;
        new_len_nxt     = HALF_LEN;
        new_ptr_alt_nxt = HALF_PTR;
        new_len_alt_nxt = HALF_LEN;
        new_mode_nxt    = MODE_LISTEN;
        read_offset_nxt = '0;
      end
      MODE_OVERFLOW: begin
        if (!unread_alt) begin
          new_ptr_nxt     = new_base;
          new_len_nxt     = HALF_LEN;
          new_ptr_alt_nxt = '0;
          new_len_alt_nxt = '0;
          new_mode_nxt    = MODE_LISTEN;
          update_all_nxt  = 1'b1;
        end
      end
      default: begin
        if (!unread_alt && alt_unset) begin
          new_ptr_alt_nxt = new_base;
          new_len_alt_nxt = HALF_LEN;
          update_alt_nxt  = 1'b1;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      read_offset_r <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      if (advance) begin
        read_offset_r <= read_offset_nxt;
        out_valid_r   <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r   <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      prime_addr_r  <= prime_addr_nxt;
      prime_len_r   <= prime_len_nxt;
      flip_addr_r   <= flip_addr_nxt;
      flip_len_r    <= flip_len_nxt;
      update_all_r  <= update_all_nxt;
      update_alt_r  <= update_alt_nxt;
      progress_ok_r <= progress_ok_nxt;
      new_ptr_r     <= new_ptr_nxt;
      new_len_r     <= new_len_nxt;
      new_ptr_alt_r <= new_ptr_alt_nxt;
      new_len_alt_r <= new_len_alt_nxt;
      new_mode_r    <= new_mode_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_prime_addr  = prime_addr_r;
  assign out_prime_len   = prime_len_r;
  assign out_flip_addr   = flip_addr_r;
  assign out_flip_len    = flip_len_r;
  assign out_update_all  = update_all_r;
  assign out_update_alt  = update_alt_r;
  assign out_progress_ok = progress_ok_r;
  assign out_new_ptr     = new_ptr_r;
  assign out_new_len     = new_len_r;
  assign out_new_ptr_alt = new_ptr_alt_r;
  assign out_new_len_alt = new_len_alt_r;
  assign out_new_mode    = new_mode_r;

`ifndef SYNTHESIS
  a_idle_clears_offset: assert property (@(posedge clk) disable iff (!rst_n)
    advance && s0_mode_r == MODE_IDLE |=> read_offset_r == '0)
    else $error("read offset not cleared after an idle snapshot");

  a_init_sets_all: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !progress_ok_r |-> update_all_r && new_mode_r == MODE_LISTEN)
    else $error("initialisation beat without a full register rewrite");

  a_single_update: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(update_all_r && update_alt_r))
    else $error("both update kinds requested in one beat");

  a_len_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> prime_len_r <= HALF_LEN && flip_len_r <= HALF_LEN)
    else $error("read length beyond one half");

  a_advance_fills_output: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_valid_r)
    else $error("result register empty after a beat moved in");
`endif

endmodule

`default_nettype wire
